>>> rtl/mfbd_pkg.sv
package mfbd_pkg;

    // Command codes carried on the command field.
    localparam logic [2:0] CMD_PLOT       = 3'd0;
    localparam logic [2:0] CMD_READ_PIXEL = 3'd1;
    localparam logic [2:0] CMD_FILL       = 3'd2;
    localparam logic [2:0] CMD_RECT       = 3'd3;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd4;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_RD,
        ST_WR,
        ST_CAPT,
        ST_DONE
    } mfbd_state_t;

    // Which pixel the sequencer is presenting to the pixel unit.
    typedef enum logic [1:0] {
        PH_POINT,
        PH_HORIZ,
        PH_VERT
    } mfbd_phase_t;

    // Pixel unit result: on-panel flag and the bit row inside the byte.
    typedef struct packed {
        logic       hit;
        logic [2:0] bit_sel;
    } pix_info_t;

endpackage

>>> rtl/mfbd_frame_mem.sv
module mfbd_frame_mem #(
    parameter int DEPTH = 384,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Single port: a cycle either writes or reads, and read data is registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mfbd_pixel_unit.sv
module mfbd_pixel_unit
    import mfbd_pkg::*;
#(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 48,
    parameter int PAGE_COUNT   = 6,
    parameter int AW           = 9
) (
    input  logic signed [7:0] x,
    input  logic signed [7:0] y,
    output pix_info_t         info,
    output logic [AW-1:0]     addr
);

    localparam int CW = AW + 4;

    logic       x_ok;
    logic       y_ok;
    logic       page_ok;
    logic [3:0] page;
    logic [CW-1:0] addr_full;

    assign page    = y[6:3];
    assign x_ok    = !x[7] && ({1'b0, x} < 9'(PANEL_WIDTH));
    assign y_ok    = !y[7] && ({1'b0, y} < 9'(PANEL_HEIGHT));
    assign page_ok = {1'b0, page} < 5'(PAGE_COUNT);

    // Address is only meaningful when the pixel is on the panel.
    assign addr_full = CW'(page) * CW'(PANEL_WIDTH) + CW'(x[6:0]);
    assign addr      = addr_full[AW-1:0];

    assign info.hit     = x_ok && y_ok && page_ok;
    assign info.bit_sel = y[2:0];

endmodule

>>> rtl/mono_page_framebuffer_draw.sv
// Channel   Direction  Handshake            Words
// input     in         in_valid / in_stall  command, x_first, y_first, x_second,
//                                           y_second, color, byte_index
// output    out        out_valid / out_stall pixel_value, byte_value
//
// Every command gives one output word. Plot reads a byte, then writes it back through
// the single memory port; a rectangle does so per perimeter pixel visit. Read pixel
// and read byte read, then capture. A fill writes all PANEL_WIDTH*PAGE_COUNT bytes.
// After reset a clearing pass writes zero to all PANEL_WIDTH*PAGE_COUNT bytes, one a
// cycle, with in_stall high. in_stall is low only in the idle state; a finished
// word waits in the sequencer while an earlier one is stalled at the output.
module mono_page_framebuffer_draw
    import mfbd_pkg::*;
#(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 48,
    parameter int PAGE_COUNT   = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        command,
    input  logic signed [7:0] x_first,
    input  logic signed [7:0] y_first,
    input  logic signed [7:0] x_second,
    input  logic signed [7:0] y_second,
    input  logic              color,
    input  logic [8:0]        byte_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              pixel_value,
    output logic [7:0]        byte_value
);

    localparam int DEPTH = PANEL_WIDTH * PAGE_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = (AW > 9) ? AW : 9;

    // Control state.
    mfbd_state_t state_reg, state_next;
    mfbd_phase_t phase_reg, phase_next;
    logic        side_reg, side_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic        out_valid_reg, out_valid_next;

    // Command operands, held while the command runs.
    logic [2:0]        cmd_reg, cmd_next;
    logic signed [7:0] xa_reg, xa_next;
    logic signed [7:0] ya_reg, ya_next;
    logic signed [7:0] xb_reg, xb_next;
    logic signed [7:0] yb_reg, yb_next;
    logic              color_reg, color_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic signed [8:0] cur_reg, cur_next;

    // Pending and delivered results.
    logic       pix_res_reg, pix_res_next;
    logic [7:0] byte_res_reg, byte_res_next;
    logic       pixel_value_reg, pixel_value_next;
    logic [7:0] byte_value_reg, byte_value_next;

    // Shared pixel unit and memory port.
    logic signed [7:0] pt_x;
    logic signed [7:0] pt_y;
    pix_info_t         pix_info;
    logic [AW-1:0]     pix_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;
    logic [7:0]        bit_mask;
    logic              idx_ok;
    logic              out_free;

    // The walker presents one pixel at a time to the pixel unit.
    always_comb
    begin
        case (phase_reg)
            PH_HORIZ:
            begin
                pt_x = cur_reg[7:0];
                pt_y = side_reg ? yb_reg : ya_reg;
            end
            PH_VERT:
            begin
                pt_x = side_reg ? xb_reg : xa_reg;
                pt_y = cur_reg[7:0];
            end
            default:
            begin
                pt_x = xa_reg;
                pt_y = ya_reg;
            end
        endcase
    end

    mfbd_pixel_unit #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .PAGE_COUNT   (PAGE_COUNT),
        .AW           (AW)
    ) u_pixel (
        .x    (pt_x),
        .y    (pt_y),
        .info (pix_info),
        .addr (pix_addr)
    );

    mfbd_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign bit_mask = 8'd1 << pix_info.bit_sel;
    assign idx_ok   = idx_reg < IW'(DEPTH);
    assign out_free = !out_valid_reg || !out_stall;

    // Memory port: sweeps write whole bytes, draws read then write back, reads only read.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = pix_addr;
        mem_wdata = BYTE_ZEROS;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = sweep_reg;
                mem_wdata = BYTE_ZEROS;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_addr  = sweep_reg;
                mem_wdata = color_reg ? BYTE_ONES : BYTE_ZEROS;
            end
            ST_RD:
            begin
                mem_addr = (cmd_reg == CMD_READ_BYTE) ? idx_reg[AW-1:0] : pix_addr;
            end
            ST_WR:
            begin
                mem_we    = pix_info.hit;
                mem_wdata = color_reg ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        side_next        = side_reg;
        sweep_next       = sweep_reg;
        out_valid_next   = out_valid_reg;
        cmd_next         = cmd_reg;
        xa_next          = xa_reg;
        ya_next          = ya_reg;
        xb_next          = xb_reg;
        yb_next          = yb_reg;
        color_next       = color_reg;
        idx_next         = idx_reg;
        cur_next         = cur_reg;
        pix_res_next     = pix_res_reg;
        byte_res_next    = byte_res_reg;
        pixel_value_next = pixel_value_reg;
        byte_value_next  = byte_value_reg;
        in_stall         = 1'b1;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_next      = command;
                    xa_next       = x_first;
                    ya_next       = y_first;
                    xb_next       = x_second;
                    yb_next       = y_second;
                    color_next    = color;
                    idx_next      = IW'(byte_index);
                    cur_next      = {x_first[7], x_first};
                    side_next     = 1'b0;
                    phase_next    = PH_POINT;
                    sweep_next    = '0;
                    pix_res_next  = 1'b0;
                    byte_res_next = BYTE_ZEROS;
                    case (command)
                        CMD_PLOT, CMD_READ_PIXEL, CMD_READ_BYTE:
                        begin
                            state_next = ST_RD;
                        end
                        CMD_FILL:
                        begin
                            state_next = ST_FILL;
                        end
                        CMD_RECT:
                        begin
                            phase_next = PH_HORIZ;
                            if ((x_second < x_first) || (y_second < y_first))
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD:
            begin
                if ((cmd_reg == CMD_PLOT) || (cmd_reg == CMD_RECT))
                begin
                    state_next = ST_WR;
                end
                else
                begin
                    state_next = ST_CAPT;
                end
            end
            ST_WR:
            begin
                state_next = ST_RD;
                case (phase_reg)
                    PH_HORIZ:
                    begin
                        side_next = !side_reg;
                        if (side_reg)
                        begin
                            if (cur_reg == {xb_reg[7], xb_reg})
                            begin
                                // Top and bottom done; the sides cover the rows between.
                                cur_next   = {ya_reg[7], ya_reg} + 9'sd1;
                                phase_next = PH_VERT;
                                if ((ya_reg + 9'sd1) >= yb_reg)
                                begin
                                    state_next = ST_DONE;
                                end
                            end
                            else
                            begin
                                cur_next = cur_reg + 9'sd1;
                            end
                        end
                    end
                    PH_VERT:
                    begin
                        side_next = !side_reg;
                        if (side_reg)
                        begin
                            cur_next = cur_reg + 9'sd1;
                            if ((cur_reg + 9'sd1) == {yb_reg[7], yb_reg})
                            begin
                                state_next = ST_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CAPT:
            begin
                if (cmd_reg == CMD_READ_BYTE)
                begin
                    byte_res_next = idx_ok ? mem_rdata : BYTE_ZEROS;
                end
                else
                begin
                    pix_res_next = pix_info.hit && mem_rdata[pix_info.bit_sel];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    pixel_value_next = pix_res_reg;
                    byte_value_next  = byte_res_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_POINT;
            side_reg      <= 1'b0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            side_reg      <= side_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        xa_reg          <= xa_next;
        ya_reg          <= ya_next;
        xb_reg          <= xb_next;
        yb_reg          <= yb_next;
        color_reg       <= color_next;
        idx_reg         <= idx_next;
        cur_reg         <= cur_next;
        pix_res_reg     <= pix_res_next;
        byte_res_reg    <= byte_res_next;
        pixel_value_reg <= pixel_value_next;
        byte_value_reg  <= byte_value_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;
    assign byte_value  = byte_value_reg;

    // A new output word only ever comes from the done state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("output word raised outside the done state");

    // The clearing pass writes nothing but zeros.
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && mem_we) |-> mem_wdata == BYTE_ZEROS)
        else $error("clearing pass wrote a nonzero byte");

    // Pixel write-back only touches pixels on the panel.
    a_wr_on_panel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR && mem_we) |-> pix_info.hit)
        else $error("write-back to a pixel off the panel");

    // A waiting output word is never overwritten.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(byte_value_reg)
            && $stable(pixel_value_reg))
        else $error("stalled output word changed");

endmodule

>>> bench/tb_mono_page_framebuffer_draw.sv
module tb_mono_page_framebuffer_draw;
    import mfbd_pkg::*;

    // Panel geometry; the same values are passed to the block below.
    localparam int PANEL_WIDTH  = 64;
    localparam int PANEL_HEIGHT = 48;
    localparam int PAGE_COUNT   = 6;
    localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;

    // The block treats the three top command codes as no-operations.
    localparam logic [2:0] CMD_UNUSED_A = 3'd5;
    localparam logic [2:0] CMD_UNUSED_B = 3'd6;
    localparam logic [2:0] CMD_UNUSED_C = 3'd7;

    localparam int RANDOM_PER_PHASE = 185;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 50;
    localparam int REPORT_LIMIT     = 10;

    // One drawing command as it travels on the input channel.
    typedef struct packed {
        logic [2:0]        command;
        logic signed [7:0] x_first;
        logic signed [7:0] y_first;
        logic signed [7:0] x_second;
        logic signed [7:0] y_second;
        logic              color;
        logic [8:0]        byte_index;
    } draw_word_t;

    // One readback word as it leaves on the output channel.
    typedef struct packed {
        logic       pixel_value;
        logic [7:0] byte_value;
    } readback_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [2:0]        command    = CMD_PLOT;
    logic signed [7:0] x_first    = '0;
    logic signed [7:0] y_first    = '0;
    logic signed [7:0] x_second   = '0;
    logic signed [7:0] y_second   = '0;
    logic              color      = 1'b0;
    logic [8:0]        byte_index = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              pixel_value;
    logic [7:0]        byte_value;

    mono_page_framebuffer_draw #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_HEIGHT(PANEL_HEIGHT),
        .PAGE_COUNT  (PAGE_COUNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .x_first    (x_first),
        .y_first    (y_first),
        .x_second   (x_second),
        .y_second   (y_second),
        .color      (color),
        .byte_index (byte_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_value(pixel_value),
        .byte_value (byte_value)
    );

    // Our own copy of the page-organized frame: byte page*width+column holds
    // eight stacked pixels, row y sitting in bit y&7 of page y>>3.
    logic [7:0] page_bytes [STORE_BYTES];

    draw_word_t  draw_queue[$];
    readback_t   readback_due[$];
    int unsigned words_queued   = 0;
    int unsigned words_accepted = 0;
    int unsigned fail_count     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    bit          hold_request   = 1'b0;
    bit          hold_taken;
    int unsigned hold_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A pixel exists only inside the panel and on an existing page.
    function automatic bit on_panel(input int x, input int y);
        if (x < 0 || x >= PANEL_WIDTH || y < 0 || y >= PANEL_HEIGHT)
            return 1'b0;
        return (y >> 3) < PAGE_COUNT;
    endfunction

    function automatic bit dot_at(input int x, input int y);
        if (!on_panel(x, y))
            return 1'b0;
        return page_bytes[(y >> 3) * PANEL_WIDTH + x][y & 7];
    endfunction

    // Off-panel writes are clipped away one pixel at a time.
    task automatic put_dot(input int x, input int y, input bit on);
        if (on_panel(x, y))
            page_bytes[(y >> 3) * PANEL_WIDTH + x][y & 7] = on;
    endtask

    // Applies one accepted command to the frame copy and works out the word
    // that the block must return for it.
    task automatic apply_draw_word(input draw_word_t w, output readback_t r);
        int xa;
        int ya;
        int xb;
        int yb;
        int i;
        xa = $signed(w.x_first);
        ya = $signed(w.y_first);
        xb = $signed(w.x_second);
        yb = $signed(w.y_second);
        r = '0;
        case (w.command)
            CMD_PLOT:
                put_dot(xa, ya, w.color);
            CMD_READ_PIXEL:
                r.pixel_value = dot_at(xa, ya);
            CMD_FILL:
                foreach (page_bytes[k])
                    page_bytes[k] = w.color ? BYTE_ONES : BYTE_ZEROS;
            CMD_RECT:
                // An inverted rectangle draws nothing. The top and bottom rows
                // span the full width, the side columns only the rows between.
                if (xb >= xa && yb >= ya)
                begin
                    for (i = xa; i <= xb; i++)
                    begin
                        put_dot(i, ya, w.color);
                        put_dot(i, yb, w.color);
                    end
                    for (i = ya + 1; i < yb; i++)
                    begin
                        put_dot(xa, i, w.color);
                        put_dot(xb, i, w.color);
                    end
                end
            CMD_READ_BYTE:
                if (w.byte_index < STORE_BYTES)
                    r.byte_value = page_bytes[w.byte_index];
            default:
                ;
        endcase
    endtask

    // Sender: a word stays on the port until it is taken, and the next one is
    // offered or the channel idles only once the current one has gone.
    always @(posedge clk or negedge rst_n)
    begin
        draw_word_t w;
        readback_t  r;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            command    <= CMD_PLOT;
            x_first    <= '0;
            y_first    <= '0;
            x_second   <= '0;
            y_second   <= '0;
            color      <= 1'b0;
            byte_index <= '0;
            foreach (page_bytes[k])
                page_bytes[k] = BYTE_ZEROS;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                w = '{command, x_first, y_first, x_second, y_second, color, byte_index};
                apply_draw_word(w, r);
                readback_due.push_back(r);
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (draw_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = draw_queue.pop_front();
                    in_valid   <= 1'b1;
                    command    <= w.command;
                    x_first    <= w.x_first;
                    y_first    <= w.y_first;
                    x_second   <= w.x_second;
                    y_second   <= w.y_second;
                    color      <= w.color;
                    byte_index <= w.byte_index;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure. Once requested, a long hold keeps the output
    // stalled so that the block backs up and stalls its own input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_request && !hold_taken)
        begin
            out_stall  <= 1'b1;
            hold_left  <= LONG_HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Checker: each word taken from the output is matched against the oldest
    // expected readback.
    always @(posedge clk)
    begin
        readback_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (readback_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected output word: pixel %0d byte 0x%02h",
                             pixel_value, byte_value);
            end
            else
            begin
                want = readback_due.pop_front();
                if (pixel_value !== want.pixel_value || byte_value !== want.byte_value)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("readback mismatch: pixel exp %0d got %0d, byte exp 0x%02h got 0x%02h",
                                 want.pixel_value, pixel_value, want.byte_value, byte_value);
                end
            end
        end
    end

    function automatic draw_word_t make_word(input logic [2:0] cmd, input int xa, input int ya,
                                             input int xb, input int yb, input bit c,
                                             input int idx);
        draw_word_t w;
        w.command    = cmd;
        w.x_first    = 8'(xa);
        w.y_first    = 8'(ya);
        w.x_second   = 8'(xb);
        w.y_second   = 8'(yb);
        w.color      = c;
        w.byte_index = 9'(idx);
        return w;
    endfunction

    // Coordinates mostly land on the panel, the rest anywhere in the 8-bit range.
    function automatic logic signed [7:0] pick_coord(input int span);
        if ($urandom_range(99) < 75)
            return 8'($urandom_range(span - 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic draw_word_t random_word();
        draw_word_t  w;
        int unsigned roll;
        w.x_first    = 8'($urandom_range(255));
        w.y_first    = 8'($urandom_range(255));
        w.x_second   = 8'($urandom_range(255));
        w.y_second   = 8'($urandom_range(255));
        w.color      = ($urandom_range(99) < 65);
        w.byte_index = ($urandom_range(99) < 80) ? 9'($urandom_range(STORE_BYTES - 1))
                                                 : 9'($urandom_range(511));
        roll = $urandom_range(99);
        if (roll < 30)
            w.command = CMD_PLOT;
        else if (roll < 52)
            w.command = CMD_READ_PIXEL;
        else if (roll < 72)
            w.command = CMD_READ_BYTE;
        else if (roll < 90)
            w.command = CMD_RECT;
        else if (roll < 94)
            w.command = CMD_FILL;
        else if (roll < 96)
            w.command = CMD_UNUSED_A;
        else if (roll < 98)
            w.command = CMD_UNUSED_B;
        else
            w.command = CMD_UNUSED_C;
        if (w.command == CMD_PLOT || w.command == CMD_READ_PIXEL || w.command == CMD_RECT)
        begin
            w.x_first = pick_coord(PANEL_WIDTH);
            w.y_first = pick_coord(PANEL_HEIGHT);
        end
        // Most rectangles are small so that the run stays short; a few are
        // inverted and a few span arbitrary coordinates.
        if (w.command == CMD_RECT)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                w.x_second = w.x_first + 8'($urandom_range(12));
                w.y_second = w.y_first + 8'($urandom_range(12));
            end
            else if (roll < 92)
            begin
                w.x_second = w.x_first - 8'($urandom_range(5));
                w.y_second = w.y_first - 8'($urandom_range(5));
            end
        end
        return w;
    endfunction

    task automatic queue_word(input draw_word_t w);
        draw_queue.push_back(w);
        words_queued++;
    endtask

    task automatic wait_all_taken();
        while (words_accepted != words_queued)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: reset contents, extremes, clipping, inverted and
        // single-pixel rectangles, fills and the unused command codes.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_word(make_word(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, 0));
        queue_word(make_word(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
        queue_word(make_word(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, STORE_BYTES));
        queue_word(make_word(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, 511));
        queue_word(make_word(CMD_PLOT, 0, 0, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_PLOT, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_READ_PIXEL, 0, 0, 0, 0, 1'b0, 0));
        queue_word(make_word(CMD_READ_PIXEL, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 1'b0, 0));
        queue_word(make_word(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
        queue_word(make_word(CMD_PLOT, PANEL_WIDTH, 0, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_PLOT, -1, 5, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_PLOT, 0, PANEL_HEIGHT, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_PLOT, -128, 127, 127, -128, 1'b1, 0));
        queue_word(make_word(CMD_READ_PIXEL, PANEL_WIDTH, 0, 0, 0, 1'b0, 0));
        queue_word(make_word(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, PANEL_WIDTH - 1));
        queue_word(make_word(CMD_PLOT, 0, 0, 0, 0, 1'b0, 0));
        queue_word(make_word(CMD_RECT, 10, 5, 9, 20, 1'b1, 0));
        queue_word(make_word(CMD_RECT, 5, 10, 20, 9, 1'b1, 0));
        queue_word(make_word(CMD_RECT, 3, 3, 3, 3, 1'b1, 0));
        queue_word(make_word(CMD_RECT, -10, 2, 80, 40, 1'b1, 0));
        queue_word(make_word(CMD_RECT, -128, -128, 127, 127, 1'b1, 0));
        queue_word(make_word(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, 10));
        queue_word(make_word(CMD_FILL, 0, 0, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_RECT, 1, 1, 30, 20, 1'b0, 0));
        queue_word(make_word(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, PANEL_WIDTH + 1));
        queue_word(make_word(CMD_UNUSED_A, 0, 0, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_UNUSED_B, 0, 0, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_UNUSED_C, 0, 0, 0, 0, 1'b1, 0));
        queue_word(make_word(CMD_FILL, 0, 0, 0, 0, 1'b0, 0));
        wait_all_taken();

        // Random part, first with a lightly idling sender and a busy receiver,
        // then the other way round.
        send_idle_pct = 15;
        recv_idle_pct = 47;
        repeat (RANDOM_PER_PHASE) queue_word(random_word());
        wait_all_taken();

        send_idle_pct = 47;
        recv_idle_pct = 15;
        repeat (RANDOM_PER_PHASE) queue_word(random_word());
        wait_all_taken();

        // No idling on either side, with one long output hold while the
        // sender keeps offering words.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) queue_word(random_word());
        hold_request = 1'b1;
        wait_all_taken();

        while (readback_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[mono_page_framebuffer_draw] OK");
        else
            $display("[mono_page_framebuffer_draw] ERROR");
        $finish;
    end

    // Watchdog sized well beyond the slowest legal run.
    initial
    begin
        #60000000;
        $display("[mono_page_framebuffer_draw] ERROR");
        $finish;
    end

endmodule
